>>> rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants for the round-robin thread scheduler
// Slot states, result codes, actions and field widths.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int NumSlots  = 128;
  localparam int SlotBits  = 7;
  localparam int ValueBits = 32;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_BLOCK = 2'd3;

  localparam logic [2:0] CODE_OK      = 3'd0;
  localparam logic [2:0] CODE_NOSUCH  = 3'd1;
  localparam logic [2:0] CODE_FULL    = 3'd2;
  localparam logic [2:0] CODE_BLOCKED = 3'd3;
  localparam logic [2:0] CODE_NORUN   = 3'd4;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_EXIT   = 3'd2;
  localparam logic [2:0] ACT_JOIN   = 3'd3;
  localparam logic [2:0] ACT_SELF   = 3'd4;

  // Search request broadcast to the cell row.
  localparam logic [1:0] SRCH_RUNNABLE = 2'd0; // ready or running
  localparam logic [1:0] SRCH_READY    = 2'd1; // ready only
  localparam logic [1:0] SRCH_EMPTY    = 2'd2; // empty only

  // Command to the cell row: write one slot.
  typedef struct packed {
    logic                 wr;
    logic [SlotBits-1:0]  idx;
    logic                 set_status;
    logic [1:0]           status;
    logic                 set_ret;
    logic                 ret;
    logic                 set_jv;
    logic                 jv;
    logic                 set_jid;
    logic [SlotBits-1:0]  jid;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                ret;
    logic                jv;
    logic [SlotBits-1:0] jid;
  } slot_info_t;

endpackage

>>> rtl/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram: generic single-port-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rrts_cell.sv
// ----------------------------------------------------------------------------
// rrts_cell: one thread slot of the scheduler row
// Holds slot status, returned flag and joiner link; passes the search token on.
// ----------------------------------------------------------------------------
module rrts_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rrts_pkg::SlotBits-1:0] my_idx,
  input  logic [1:0]                    reset_status,
  input  rrts_pkg::cell_cmd_t           cmd,
  input  logic [1:0]                    srch_kind,
  input  logic                          tok_in,   // token from left neighbor
  output logic                          tok_out,  // token to right neighbor
  output logic                          match,
  output rrts_pkg::slot_info_t          info
);

  logic [1:0]                    status_r, status_nxt;
  logic                          ret_r, ret_nxt;
  logic                          jv_r, jv_nxt;
  logic [rrts_pkg::SlotBits-1:0] jid_r, jid_nxt;
  logic                          tok_r;
  logic                          hit;
  logic                          sel;

  assign sel = cmd.wr && (cmd.idx == my_idx);

  always_comb begin
    status_nxt = status_r;
    ret_nxt    = ret_r;
    jv_nxt     = jv_r;
    jid_nxt    = jid_r;
    if (sel) begin
      if (cmd.set_status) status_nxt = cmd.status;
      if (cmd.set_ret)    ret_nxt    = cmd.ret;
      if (cmd.set_jv)     jv_nxt     = cmd.jv;
      if (cmd.set_jid)    jid_nxt    = cmd.jid;
    end
  end

  always_comb begin
    case (srch_kind)
      rrts_pkg::SRCH_RUNNABLE:
        hit = (status_r == rrts_pkg::ST_READY) || (status_r == rrts_pkg::ST_RUN);
      rrts_pkg::SRCH_READY: hit = (status_r == rrts_pkg::ST_READY);
      rrts_pkg::SRCH_EMPTY: hit = (status_r == rrts_pkg::ST_EMPTY);
      default:              hit = 1'b0;
    endcase
  end

  // Token is registered here; a match is taken by the controller, else pass on.
  assign match   = tok_r && hit;
  assign tok_out = tok_r && !hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= reset_status;
      ret_r    <= 1'b0;
      jv_r     <= 1'b0;
      tok_r    <= 1'b0;
    end else begin
      status_r <= status_nxt;
      ret_r    <= ret_nxt;
      jv_r     <= jv_nxt;
      tok_r    <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    jid_r <= jid_nxt;
  end

  assign info = '{status: status_r, ret: ret_r, jv: jv_r, jid: jid_r};

endmodule

>>> rtl/rrts_row.sv
// ----------------------------------------------------------------------------
// rrts_row: ring of slot cells
// Token enters at the slot after the start index and walks one slot a cycle.
// ----------------------------------------------------------------------------
module rrts_row (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrts_pkg::cell_cmd_t           cmd,
  input  logic [1:0]                    srch_kind,
  input  logic                          srch_start,
  input  logic                          srch_abort,
  input  logic [rrts_pkg::SlotBits-1:0] srch_from,
  input  logic [rrts_pkg::SlotBits-1:0] rd_idx,
  output logic                          found,
  output logic [rrts_pkg::SlotBits-1:0] found_idx,
  output rrts_pkg::slot_info_t          rd_info
);

  localparam int N = rrts_pkg::NumSlots;

  logic [N-1:0]         tok_out;
  logic [N-1:0]         tok_in;
  logic [N-1:0]         match;
  rrts_pkg::slot_info_t info [N];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic [rrts_pkg::SlotBits-1:0] inj;
      assign inj = srch_from + rrts_pkg::SlotBits'(1);
      assign tok_in[g] = srch_abort ? 1'b0 :
                         ((srch_start && inj == rrts_pkg::SlotBits'(g)) ||
                          tok_out[(g + N - 1) % N]);
      rrts_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .my_idx       (rrts_pkg::SlotBits'(g)),
        .reset_status ((g == 0) ? rrts_pkg::ST_RUN : rrts_pkg::ST_EMPTY),
        .cmd          (cmd),
        .srch_kind    (srch_kind),
        .tok_in       (tok_in[g]),
        .tok_out      (tok_out[g]),
        .match        (match[g]),
        .info         (info[g])
      );
    end
  endgenerate

  // At most one token is live, so at most one match.
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) found_idx = rrts_pkg::SlotBits'(i);
    end
  end
  assign found   = |match;
  assign rd_info = info[rd_idx];

endmodule

>>> rtl/round_robin_thread_scheduler_top.sv
// A request reads slot info (S_LOOK), decides (S_DEC), then walks the search token slot by slot
// if needed; a blocking join or an exit that wakes a joiner adds an S_WR2 write, and a tick
// that switches adds a promote step. Self, join hit and a failed exit or join skip the walk.
// Requests are taken one at a time; the next is taken the cycle after the result
// is registered, and S_DONE holds while an earlier result waits on out_tready.
// Reset: slot 0 running, all others empty, returned flags and joiner links clear,
// current slot 0. Exit values are unknown until written.
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top: round-robin thread slot scheduler
// Tick, create, exit, join and self requests over a ring of slot cells.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // action[2:0], target_thread[9:3], exit_value[41:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // code[2:0], thread_id[9:3], joined_value[41:10],
                                  // woke_joiner[42], woken_id[49:43], switched[50]
);

  localparam int SB = rrts_pkg::SlotBits;
  localparam int VB = rrts_pkg::ValueBits;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1; // read slot info
  localparam logic [2:0] S_DEC   = 3'd2; // decide, start search
  localparam logic [2:0] S_WALK  = 3'd3; // token walking
  localparam logic [2:0] S_DONE  = 3'd4; // push result
  localparam logic [2:0] S_WR2   = 3'd5; // second slot write, then start search

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    act_r;
  logic [SB-1:0] tgt_r;
  logic [VB-1:0] xval_r;
  logic [SB-1:0] cur_r, cur_nxt;
  logic [SB:0]   walk_r, walk_nxt;

  logic [2:0]    code_r, code_nxt;
  logic [SB-1:0] tid_r, tid_nxt;
  logic          jsel_r, jsel_nxt;    // joined value comes from RAM
  logic          jx_r, jx_nxt;        // joined value is exit value
  logic          woke_r, woke_nxt;
  logic [SB-1:0] wid_r, wid_nxt;
  logic          sw_r, sw_nxt;

  logic          ov_r;
  logic [55:0]   od_r;

  rrts_pkg::cell_cmd_t  cmd;
  rrts_pkg::slot_info_t rd_info;
  logic [1:0]    srch_kind_r, srch_kind_nxt;
  logic          srch_start, srch_abort, found;
  logic [SB-1:0] found_idx, rd_idx;
  logic          ram_we;
  logic [VB-1:0] ram_q;
  logic          in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign rd_idx    = (act_r == rrts_pkg::ACT_JOIN && state_r == S_LOOK) ? tgt_r : cur_r;

  rrts_row u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .srch_kind  (srch_kind_r),
    .srch_start (srch_start),
    .srch_abort (srch_abort),
    .srch_from  (cur_r),
    .rd_idx     (rd_idx),
    .found      (found),
    .found_idx  (found_idx),
    .rd_info    (rd_info)
  );

  rrts_ram #(.Width(VB), .Depth(rrts_pkg::NumSlots)) u_vals (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r),
    .wdata (xval_r),
    .raddr (tgt_r),
    .rdata (ram_q)
  );

  // Latched info: target (join) seen in S_LOOK, current slot seen in S_IDLE.
  rrts_pkg::slot_info_t tinfo_r, cinfo_r;
  logic                 cur_run;
  assign cur_run = (cinfo_r.status == rrts_pkg::ST_RUN);

  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      tinfo_r <= rd_info;
    end
    if (state_r == S_IDLE) begin
      cinfo_r <= rd_info;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    walk_nxt      = walk_r;
    code_nxt      = code_r;
    tid_nxt       = tid_r;
    jsel_nxt      = jsel_r;
    jx_nxt        = jx_r;
    woke_nxt      = woke_r;
    wid_nxt       = wid_r;
    sw_nxt        = sw_r;
    srch_kind_nxt = srch_kind_r;
    srch_start    = 1'b0;
    srch_abort    = 1'b0;
    ram_we        = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        code_nxt = rrts_pkg::CODE_OK;
        tid_nxt  = cur_r;
        jsel_nxt = 1'b0;
        jx_nxt   = 1'b0;
        woke_nxt = 1'b0;
        wid_nxt  = '0;
        sw_nxt   = 1'b0;
        state_nxt = S_DONE;
        case (act_r)
          rrts_pkg::ACT_TICK: begin
            srch_kind_nxt = rrts_pkg::SRCH_RUNNABLE;
            srch_start = 1'b1;
            state_nxt  = S_WALK;
          end
          rrts_pkg::ACT_CREATE: begin
            srch_kind_nxt = rrts_pkg::SRCH_EMPTY;
            srch_start = 1'b1;
            state_nxt  = S_WALK;
          end
          rrts_pkg::ACT_EXIT: begin
            if (!cur_run) begin
              code_nxt = rrts_pkg::CODE_NORUN;
            end else begin
              ram_we = 1'b1;
              cmd.wr = 1'b1;
              cmd.idx = cur_r;
              cmd.set_status = 1'b1;
              cmd.status = rrts_pkg::ST_EMPTY;
              cmd.set_ret = 1'b1;
              cmd.ret = !cinfo_r.jv;
              cmd.set_jv = 1'b1;
              cmd.jv = 1'b0;
              srch_kind_nxt = rrts_pkg::SRCH_READY;
              if (cinfo_r.jv) begin
                woke_nxt = 1'b1;
                wid_nxt  = cinfo_r.jid;
                jx_nxt   = 1'b1;
                // wake the joiner before the search starts
                state_nxt = S_WR2;
              end else begin
                srch_start = 1'b1;
                state_nxt  = S_WALK;
              end
            end
          end
          rrts_pkg::ACT_JOIN: begin
            if (!cur_run) begin
              code_nxt = rrts_pkg::CODE_NORUN;
            end else if (tinfo_r.ret) begin
              jsel_nxt = 1'b1;
              cmd.wr = 1'b1;
              cmd.idx = tgt_r;
              cmd.set_ret = 1'b1;
              cmd.ret = 1'b0;
            end else if (tinfo_r.status == rrts_pkg::ST_EMPTY || tgt_r == cur_r ||
                         tinfo_r.jv) begin
              code_nxt = rrts_pkg::CODE_NOSUCH;
            end else begin
              cmd.wr = 1'b1;
              cmd.idx = tgt_r;
              cmd.set_jv = 1'b1;
              cmd.jv = 1'b1;
              cmd.set_jid = 1'b1;
              cmd.jid = cur_r;
              srch_kind_nxt = rrts_pkg::SRCH_READY;
              state_nxt  = S_WR2;
            end
          end
          rrts_pkg::ACT_SELF: begin
            if (!cur_run) code_nxt = rrts_pkg::CODE_NORUN;
          end
          default: ;
        endcase
        walk_nxt = '0;
      end
      S_WR2: begin
        // exit: release the joiner; join: block the caller
        cmd.wr = 1'b1;
        cmd.set_status = 1'b1;
        if (act_r == rrts_pkg::ACT_EXIT) begin
          cmd.idx = wid_r;
          cmd.status = rrts_pkg::ST_READY;
        end else begin
          cmd.idx = cur_r;
          cmd.status = rrts_pkg::ST_BLOCK;
        end
        srch_start = 1'b1;
        walk_nxt   = '0;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        walk_nxt = walk_r + 1'b1;
        if (found) begin
          srch_abort = 1'b1;
          state_nxt  = S_DONE;
          case (act_r)
            rrts_pkg::ACT_CREATE: begin
              cmd.wr = 1'b1;
              cmd.idx = found_idx;
              cmd.set_status = 1'b1;
              cmd.status = rrts_pkg::ST_READY;
              cmd.set_ret = 1'b1;
              cmd.ret = 1'b0;
              cmd.set_jv = 1'b1;
              cmd.jv = 1'b0;
              tid_nxt = found_idx;
            end
            rrts_pkg::ACT_TICK: begin
              if (found_idx != cur_r) begin
                state_nxt = S_WALK;
                walk_nxt  = {1'b1, walk_r[SB-1:0]};
                cur_nxt   = found_idx;
                tid_nxt   = found_idx;
                sw_nxt    = 1'b1;
                // demote old current if it was running
                cmd.wr = 1'b1;
                cmd.idx = cur_r;
                cmd.set_status = cinfo_r.status == rrts_pkg::ST_RUN;
                cmd.status = rrts_pkg::ST_READY;
              end
            end
            default: begin
              cmd.wr = 1'b1;
              cmd.idx = found_idx;
              cmd.set_status = 1'b1;
              cmd.status = rrts_pkg::ST_RUN;
              sw_nxt  = (found_idx != cur_r);
              cur_nxt = found_idx;
              tid_nxt = found_idx;
              if (act_r == rrts_pkg::ACT_JOIN) code_nxt = rrts_pkg::CODE_BLOCKED;
            end
          endcase
        end else if (walk_r[SB]) begin
          // second phase of tick: promote the new current
          srch_abort = 1'b1;
          cmd.wr = 1'b1;
          cmd.idx = cur_r;
          cmd.set_status = 1'b1;
          cmd.status = rrts_pkg::ST_RUN;
          state_nxt = S_DONE;
        end else if (walk_r[SB-1:0] == SB'(rrts_pkg::NumSlots - 1)) begin
          // token passed the current slot: nothing found, drop it
          srch_abort = 1'b1;
          state_nxt = S_DONE;
          case (act_r)
            rrts_pkg::ACT_CREATE: code_nxt = rrts_pkg::CODE_FULL;
            default:              code_nxt = rrts_pkg::CODE_NORUN;
          endcase
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      ov_r        <= 1'b0;
      srch_kind_r <= rrts_pkg::SRCH_RUNNABLE;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      srch_kind_r <= srch_kind_nxt;
      if (state_r == S_DONE && (!ov_r || out_tready)) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    code_r <= code_nxt;
    tid_r  <= tid_nxt;
    jsel_r <= jsel_nxt;
    jx_r   <= jx_nxt;
    woke_r <= woke_nxt;
    wid_r  <= wid_nxt;
    sw_r   <= sw_nxt;
    if (in_acc) begin
      act_r  <= in_tdata[2:0];
      tgt_r  <= in_tdata[9:3];
      xval_r <= in_tdata[41:10];
    end
    if (state_r == S_DONE && (!ov_r || out_tready)) begin
      od_r <= {5'd0, sw_r, wid_r, woke_r,
               jsel_r ? ram_q : (jx_r ? xval_r : '0), tid_r, code_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(u_row.tok_in)) else $error("more than one search token");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("request taken while busy");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

endmodule
